// ----- rtl/xml_pre_size_level_encoder_top_macros.svh -----
// assertion macros for the pre/size/level encoder
`ifndef XML_PRE_SIZE_LEVEL_ENCODER_TOP_MACROS_SVH
`define XML_PRE_SIZE_LEVEL_ENCODER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define XPSE_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define XPSE_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define XPSE_ASSERT_IMP(name, ante, cons, msg)

`define XPSE_ASSERT_NEXT(name, ante, cons, msg)

`endif

`endif

// ----- rtl/xpse_pkg.sv -----
// types and constants of the pre/size/level encoder
`default_nettype none

package xpse_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int RES_FIFO_DEPTH  = 4;
    localparam int RES_FIFO_PW     = $clog2(RES_FIFO_DEPTH);
    localparam int RES_FIFO_CW     = $clog2(RES_FIFO_DEPTH + 1);

    localparam logic [31:0] DOC_PROP  = 32'h8000_0000;
    localparam logic [8:0]  LVL_NONE  = 9'h1FF;

    typedef enum logic [2:0] {
        REQ_DOC_START  = 3'd0,
        REQ_DOC_END    = 3'd1,
        REQ_ELEM_START = 3'd2,
        REQ_ELEM_END   = 3'd3,
        REQ_TEXT       = 3'd4,
        REQ_COMMENT    = 3'd5,
        REQ_PI         = 3'd6
    } req_t;

    typedef enum logic [2:0] {
        KIND_ELEM    = 3'd0,
        KIND_TEXT    = 3'd1,
        KIND_COMMENT = 3'd2,
        KIND_PI      = 3'd3,
        KIND_DOC     = 3'd4
    } kind_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } status_t;

    typedef struct packed {
        logic [31:0] rank;
        logic [31:0] size;
        logic [31:0] prop;
        kind_t       kind;
    } entry_t;

    typedef struct packed {
        logic [31:0] rank;
        logic [31:0] size;
        logic [8:0]  level;
        logic [31:0] prop;
        kind_t       kind;
        status_t     status;
        logic        last;
    } result_t;

endpackage

`default_nettype wire

// ----- rtl/xpse_ram.sv -----
// generic single write, single read ram with registered read
`default_nettype none

module xpse_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/xml_pre_size_level_encoder_top.sv -----
// top level of the xml pre/size/level tree encoder
//
// input channel s_*: one parse event per word, request code in s_tuser,
// character count of a text chunk in s_tdata. result channel m_*: node
// tuples, m_tlast marks the final tuple of an event. an event gives zero,
// one or two tuples (a flushed text node ahead of its own node); an error
// gives one tuple with status set and the state left as it was.
// the event is decoded in the cycle it is accepted and its tuples are in
// the result queue at the next edge.
// one event is taken per cycle while the four-word result queue has room
// for two tuples; the output side drains one tuple per cycle while m_tready
// is high, so s_tready drops between events that each give two tuples.
// the top of the stack lives in registers, the entries below it in a ram
// whose read port always points at the entry under the top, so a pop
// finds its new top without a wait.
// reset empties the stack and the queue at once; the ram needs no clearing.
// when the receiver stalls the queue fills and s_tready drops; nothing is
// lost or repeated.
`default_nettype none
`include "xml_pre_size_level_encoder_top_macros.svh"

module xml_pre_size_level_encoder_top #(
    parameter int STACK_DEPTH = xpse_pkg::DEF_STACK_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // char_count
    input  wire logic [2:0]   s_tuser,   // req_type
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic      [111:0] m_tdata,   // node_rank, subtree_size, node_level, property_id, pad
    output logic      [4:0]   m_tuser,   // node_kind, status
    output logic              m_tlast    // last
);

    import xpse_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int EW = $bits(entry_t);

    logic [CW-1:0]   count_reg, count_next;
    entry_t          top_reg, top_next;
    logic [31:0]     next_rank_reg, next_rank_next;
    logic [8:0]      level_reg, level_next;
    logic [31:0]     elem_cnt_reg, elem_cnt_next;
    logic [31:0]     text_cnt_reg, text_cnt_next;
    logic [31:0]     com_cnt_reg, com_cnt_next;
    logic [31:0]     pi_cnt_reg, pi_cnt_next;
    logic            pending_reg, pending_next;
    logic            fwd_reg;
    entry_t          fwd_data_reg;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    entry_t          ram_wdata;
    logic [EW-1:0]   ram_rdata;
    entry_t          below;

    logic            fire, err, full;
    req_t            req;
    result_t         res_0, res_1, text_res, own_res;
    logic [1:0]      n_res;
    logic [31:0]     pend_ext;
    logic [8:0]      lvl_dec;
    entry_t          top_fl;

    result_t                  fifo_reg [RES_FIFO_DEPTH];
    logic [RES_FIFO_PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [RES_FIFO_CW-1:0]   fill_reg;
    logic                     pop;
    result_t                  res_head;

    xpse_ram #(
        .WIDTH (EW),
        .DEPTH (STACK_DEPTH)
    ) u_stack_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign below    = fwd_reg ? fwd_data_reg : entry_t'(ram_rdata);
    assign req      = req_t'(s_tuser);
    assign fire     = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(STACK_DEPTH));
    assign pend_ext = {31'b0, pending_reg};
    assign lvl_dec  = level_reg - 9'd1;

    always_comb begin
        top_fl      = top_reg;
        top_fl.size = top_reg.size + pend_ext;

        text_res        = '0;
        text_res.rank   = next_rank_reg;
        text_res.level  = level_reg;
        text_res.prop   = text_cnt_reg;
        text_res.kind   = KIND_TEXT;
        text_res.status = ST_OK;
    end

    always_comb begin
        count_next     = count_reg;
        top_next       = top_reg;
        next_rank_next = next_rank_reg;
        level_next     = level_reg;
        elem_cnt_next  = elem_cnt_reg;
        text_cnt_next  = text_cnt_reg;
        com_cnt_next   = com_cnt_reg;
        pi_cnt_next    = pi_cnt_reg;
        pending_next   = pending_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(count_reg - CW'(1));
        ram_wdata      = top_reg;
        err            = 1'b0;
        own_res        = '0;
        own_res.last   = 1'b1;
        res_0          = '0;
        res_1          = '0;
        n_res          = 2'd0;

        if (fire) begin
            unique case (req) inside
                REQ_DOC_START: begin
                    if (full) begin
                        err            = 1'b1;
                        res_0.status   = ST_OVERFLOW;
                        res_0.last     = 1'b1;
                        n_res          = 2'd1;
                    end else begin
                        ram_we         = (count_reg != '0);
                        top_next.rank  = '0;
                        top_next.size  = '0;
                        top_next.prop  = DOC_PROP;
                        top_next.kind  = KIND_DOC;
                        count_next     = count_reg + CW'(1);
                        next_rank_next = 32'd1;
                        level_next     = '0;
                        elem_cnt_next  = '0;
                        text_cnt_next  = '0;
                        com_cnt_next   = '0;
                        pi_cnt_next    = '0;
                        pending_next   = 1'b0;
                    end
                end
                REQ_DOC_END: begin
                    if (count_reg == '0) begin
                        err          = 1'b1;
                        res_0.status = ST_UNDERFLOW;
                        res_0.last   = 1'b1;
                        n_res        = 2'd1;
                    end else begin
                        own_res.rank  = top_reg.rank;
                        own_res.size  = top_reg.size;
                        own_res.level = (top_reg.kind == KIND_DOC) ? LVL_NONE : lvl_dec;
                        own_res.prop  = top_reg.prop;
                        own_res.kind  = top_reg.kind;
                        res_0         = own_res;
                        n_res         = 2'd1;
                        count_next    = count_reg - CW'(1);
                        top_next      = below;
                    end
                end
                REQ_ELEM_START: begin
                    if ((count_reg == '0) && pending_reg) begin
                        err          = 1'b1;
                        res_0.status = ST_UNDERFLOW;
                        res_0.last   = 1'b1;
                        n_res        = 2'd1;
                    end else if (full) begin
                        err          = 1'b1;
                        res_0.status = ST_OVERFLOW;
                        res_0.last   = 1'b1;
                        n_res        = 2'd1;
                    end else begin
                        res_0          = text_res;
                        res_0.last     = 1'b1;
                        n_res          = {1'b0, pending_reg};
                        ram_we         = (count_reg != '0);
                        ram_wdata      = top_fl;
                        top_next.rank  = next_rank_reg + pend_ext;
                        top_next.size  = '0;
                        top_next.prop  = elem_cnt_reg;
                        top_next.kind  = KIND_ELEM;
                        count_next     = count_reg + CW'(1);
                        next_rank_next = next_rank_reg + pend_ext + 32'd1;
                        text_cnt_next  = text_cnt_reg + pend_ext;
                        elem_cnt_next  = elem_cnt_reg + 32'd1;
                        level_next     = level_reg + 9'd1;
                        pending_next   = 1'b0;
                    end
                end
                REQ_ELEM_END: begin
                    if (count_reg < CW'(2)) begin
                        err          = 1'b1;
                        res_0.status = ST_UNDERFLOW;
                        res_0.last   = 1'b1;
                        n_res        = 2'd1;
                    end else begin
                        own_res.rank   = top_fl.rank;
                        own_res.size   = top_fl.size;
                        own_res.level  = (top_fl.kind == KIND_DOC) ? LVL_NONE : lvl_dec;
                        own_res.prop   = top_fl.prop;
                        own_res.kind   = top_fl.kind;
                        res_0          = pending_reg ? text_res : own_res;
                        res_1          = own_res;
                        n_res          = {pending_reg, !pending_reg};
                        next_rank_next = next_rank_reg + pend_ext;
                        text_cnt_next  = text_cnt_reg + pend_ext;
                        count_next     = count_reg - CW'(1);
                        level_next     = lvl_dec;
                        top_next       = below;
                        top_next.size  = below.size + top_fl.size + 32'd1;
                        pending_next   = 1'b0;
                    end
                end
                REQ_TEXT: begin
                    if (s_tdata != '0) begin
                        pending_next = 1'b1;
                    end
                end
                REQ_COMMENT, REQ_PI: begin
                    if (count_reg == '0) begin
                        err          = 1'b1;
                        res_0.status = ST_UNDERFLOW;
                        res_0.last   = 1'b1;
                        n_res        = 2'd1;
                    end else begin
                        own_res.rank   = next_rank_reg + pend_ext;
                        own_res.size   = '0;
                        own_res.level  = level_reg;
                        own_res.prop   = (req == REQ_COMMENT) ? com_cnt_reg : pi_cnt_reg;
                        own_res.kind   = (req == REQ_COMMENT) ? KIND_COMMENT : KIND_PI;
                        res_0          = pending_reg ? text_res : own_res;
                        res_1          = own_res;
                        n_res          = {pending_reg, !pending_reg};
                        next_rank_next = next_rank_reg + pend_ext + 32'd1;
                        text_cnt_next  = text_cnt_reg + pend_ext;
                        if (req == REQ_COMMENT) begin
                            com_cnt_next = com_cnt_reg + 32'd1;
                        end else begin
                            pi_cnt_next = pi_cnt_reg + 32'd1;
                        end
                        top_next.size  = top_fl.size + 32'd1;
                        pending_next   = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign ram_raddr = AW'(count_next - CW'(2));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            next_rank_reg <= '0;
            level_reg     <= '0;
            elem_cnt_reg  <= '0;
            text_cnt_reg  <= '0;
            com_cnt_reg   <= '0;
            pi_cnt_reg    <= '0;
            pending_reg   <= 1'b0;
            fwd_reg       <= 1'b0;
        end else begin
            count_reg     <= count_next;
            next_rank_reg <= next_rank_next;
            level_reg     <= level_next;
            elem_cnt_reg  <= elem_cnt_next;
            text_cnt_reg  <= text_cnt_next;
            com_cnt_reg   <= com_cnt_next;
            pi_cnt_reg    <= pi_cnt_next;
            pending_reg   <= pending_next;
            fwd_reg       <= ram_we && (ram_waddr == ram_raddr);
        end
        top_reg      <= top_next;
        fwd_data_reg <= ram_wdata;
    end

    // result queue
    assign pop      = m_tvalid && m_tready;
    assign m_tvalid = (fill_reg != '0);
    assign s_tready = (fill_reg <= RES_FIFO_CW'(RES_FIFO_DEPTH - 2));
    assign res_head = fifo_reg[rd_ptr_reg];
    assign m_tdata  = {7'b0, res_head.prop, res_head.level, res_head.size, res_head.rank};
    assign m_tuser  = {res_head.status, res_head.kind};
    assign m_tlast  = res_head.last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + RES_FIFO_PW'(n_res);
            rd_ptr_reg <= rd_ptr_reg + RES_FIFO_PW'(pop);
            fill_reg   <= fill_reg + RES_FIFO_CW'(n_res) - RES_FIFO_CW'(pop);
        end
        if (n_res != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res_0;
        end
        if (n_res == 2'd2) begin
            fifo_reg[wr_ptr_reg + RES_FIFO_PW'(1)] <= res_1;
        end
    end

    `XPSE_ASSERT_IMP(a_fifo_bound, 1'b1, fill_reg <= RES_FIFO_CW'(RES_FIFO_DEPTH), "queue overrun")
    `XPSE_ASSERT_IMP(a_stack_bound, 1'b1, count_reg <= CW'(STACK_DEPTH), "stack count out of range")
    `XPSE_ASSERT_IMP(a_err_last, m_tvalid && (res_head.status != ST_OK), m_tlast, "error word without last")
    `XPSE_ASSERT_NEXT(a_doc_start, fire && (req == REQ_DOC_START) && !err, (next_rank_reg == 32'd1) && (level_reg == '0) && !pending_reg, "doc start did not restart counters")
    `XPSE_ASSERT_NEXT(a_elem_flush, fire && (req == REQ_ELEM_START) && !err, !pending_reg, "text left pending after element start")

endmodule

`default_nettype wire

// ----- verif/xpse_tuple_checker.sv -----
`timescale 1ns / 100ps
// scoreboard for the pre/size/level encoder: predicts node tuples and checks result words
module xpse_tuple_checker #(
    parameter int STACK_DEPTH = xpse_pkg::DEF_STACK_DEPTH
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [15:0]  s_tdata,   // char_count
    input  wire logic [2:0]   s_tuser,   // req_type
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [111:0] m_tdata,   // node_rank, subtree_size, node_level, property_id, pad
    input  wire logic [4:0]   m_tuser,   // node_kind, status
    input  wire logic         m_tlast,
    output logic      [31:0]  fail_count,
    output logic      [31:0]  due_count
);
    import xpse_pkg::*;

    entry_t      frames [STACK_DEPTH];
    int unsigned depth_cnt;
    logic [31:0] next_rank;
    logic [31:0] elem_ids, text_ids, comment_ids, pi_ids;
    logic [8:0]  level;
    bit          text_held;
    result_t     batch [$];
    result_t     tuples_due [$];
    result_t     got, want, t;
    entry_t      popped;
    int unsigned mismatches = 0;

    assign fail_count = mismatches;

    initial due_count = '0;

    task automatic report_mismatch(input string what, input logic [31:0] got_v,
                                   input logic [31:0] want_v);
        $display("mismatch in %s: got %h, want %h at %0t", what, got_v, want_v, $realtime);
        mismatches++;
    endtask

    function automatic void add_tuple(input logic [31:0] rank, input logic [31:0] size,
                                      input logic [8:0] lvl, input logic [31:0] prop,
                                      input kind_t kind, input status_t st);
        result_t r;
        r.rank   = rank;
        r.size   = size;
        r.level  = lvl;
        r.prop   = prop;
        r.kind   = kind;
        r.status = st;
        r.last   = 1'b0;
        batch.push_back(r);
    endfunction

    function automatic void push_frame(input logic [31:0] rank, input logic [31:0] prop,
                                       input kind_t kind);
        frames[depth_cnt].rank = rank;
        frames[depth_cnt].size = '0;
        frames[depth_cnt].prop = prop;
        frames[depth_cnt].kind = kind;
        depth_cnt++;
    endfunction

    // leaf node under the current top of stack
    function automatic void add_leaf(input kind_t kind);
        logic [31:0] prop;
        case (kind)
            KIND_TEXT: begin
                prop     = text_ids;
                text_ids = text_ids + 32'd1;
            end
            KIND_COMMENT: begin
                prop        = comment_ids;
                comment_ids = comment_ids + 32'd1;
            end
            default: begin
                prop   = pi_ids;
                pi_ids = pi_ids + 32'd1;
            end
        endcase
        add_tuple(next_rank, '0, level, prop, kind, ST_OK);
        next_rank = next_rank + 32'd1;
        frames[depth_cnt - 1].size = frames[depth_cnt - 1].size + 32'd1;
    endfunction

    function automatic void flush_text();
        if (text_held) add_leaf(KIND_TEXT);
        text_held = 1'b0;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            depth_cnt   = 0;
            next_rank   = '0;
            level       = '0;
            elem_ids    = '0;
            text_ids    = '0;
            comment_ids = '0;
            pi_ids      = '0;
            text_held   = 1'b0;
            batch.delete();
            tuples_due.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.rank   = m_tdata[31:0];
                got.size   = m_tdata[63:32];
                got.level  = m_tdata[72:64];
                got.prop   = m_tdata[104:73];
                got.kind   = kind_t'(m_tuser[2:0]);
                got.status = status_t'(m_tuser[4:3]);
                got.last   = m_tlast;
                if (tuples_due.size() == 0) begin
                    report_mismatch("word with nothing due, rank", got.rank, '0);
                end else begin
                    want = tuples_due.pop_front();
                    if (got.rank !== want.rank) report_mismatch("rank", got.rank, want.rank);
                    if (got.size !== want.size) report_mismatch("size", got.size, want.size);
                    if (got.level !== want.level)
                        report_mismatch("level", 32'(got.level), 32'(want.level));
                    if (got.prop !== want.prop) report_mismatch("property", got.prop, want.prop);
                    if (got.kind !== want.kind)
                        report_mismatch("kind", 32'(got.kind), 32'(want.kind));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
            end
            if (s_tvalid && s_tready) begin
                case (s_tuser) inside
                    REQ_DOC_START: begin
                        if (depth_cnt >= STACK_DEPTH) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_OVERFLOW);
                        end else begin
                            // fresh counters, stack kept, pending text dropped
                            elem_ids    = '0;
                            text_ids    = '0;
                            comment_ids = '0;
                            pi_ids      = '0;
                            level       = '0;
                            text_held   = 1'b0;
                            push_frame('0, DOC_PROP, KIND_DOC);
                            next_rank   = 32'd1;
                        end
                    end
                    REQ_DOC_END: begin
                        if (depth_cnt == 0) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_UNDERFLOW);
                        end else begin
                            depth_cnt--;
                            popped = frames[depth_cnt];
                            add_tuple(popped.rank, popped.size,
                                      (popped.kind == KIND_DOC) ? LVL_NONE : level - 9'd1,
                                      popped.prop, popped.kind, ST_OK);
                        end
                    end
                    REQ_ELEM_START: begin
                        if (depth_cnt == 0 && text_held) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_UNDERFLOW);
                        end else if (depth_cnt >= STACK_DEPTH) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_OVERFLOW);
                        end else begin
                            flush_text();
                            push_frame(next_rank, elem_ids, KIND_ELEM);
                            next_rank = next_rank + 32'd1;
                            elem_ids  = elem_ids + 32'd1;
                            level     = level + 9'd1;
                        end
                    end
                    REQ_ELEM_END: begin
                        if (depth_cnt < 2) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_UNDERFLOW);
                        end else begin
                            flush_text();
                            depth_cnt--;
                            level  = level - 9'd1;
                            popped = frames[depth_cnt];
                            frames[depth_cnt - 1].size = frames[depth_cnt - 1].size
                                                         + popped.size + 32'd1;
                            add_tuple(popped.rank, popped.size,
                                      (popped.kind == KIND_DOC) ? LVL_NONE : level,
                                      popped.prop, popped.kind, ST_OK);
                        end
                    end
                    REQ_TEXT: begin
                        if (s_tdata != 16'd0) text_held = 1'b1;
                    end
                    REQ_COMMENT, REQ_PI: begin
                        if (depth_cnt == 0) begin
                            add_tuple('0, '0, '0, '0, KIND_ELEM, ST_UNDERFLOW);
                        end else begin
                            flush_text();
                            add_leaf((s_tuser == REQ_COMMENT) ? KIND_COMMENT : KIND_PI);
                        end
                    end
                    default: begin
                    end
                endcase
                foreach (batch[k]) begin
                    t      = batch[k];
                    t.last = (k == batch.size() - 1);
                    tuples_due.push_back(t);
                end
                batch.delete();
            end
        end
        due_count <= tuples_due.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// top of the pre/size/level encoder testbench: clock, reset, stimulus, back-pressure, verdict
module testbench;
    import xpse_pkg::*;

    localparam logic [2:0] REQ_RESERVED = 3'd7;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [15:0]  s_tdata  = '0;
    logic [2:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [111:0] m_tdata;
    logic [4:0]   m_tuser;
    logic         m_tlast;
    logic [31:0]  fail_count;
    logic [31:0]  due_count;
    int           words_sent  = 0;
    int           calm_words  = 0;
    int           stall_left  = 0;
    int           calm_cycles = 0;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    xml_pre_size_level_encoder_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    xpse_tuple_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .due_count  (due_count)
    );

    // mostly short gaps, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] chunk_length();
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [15:0] any_chars();
        return 16'($urandom_range(0, 65535));
    endfunction

    always @(posedge aclk) begin
        if (calm_cycles != 0) begin
            m_tready    <= 1'b1;
            calm_cycles <= calm_cycles - 1;
        end else if (stall_left != 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 199) == 0) calm_cycles <= $urandom_range(50, 200);
            else stall_left <= idle_length();
        end
    end

    task automatic send(input logic [2:0] req, input logic [15:0] chars);
        int gap;
        if (calm_words != 0) begin
            calm_words--;
            gap = 0;
        end else begin
            gap = idle_length();
            if ($urandom_range(0, 59) == 0) calm_words = $urandom_range(20, 60);
        end
        repeat (gap) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= chars;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // hold off until every tuple owed has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (due_count != 0) @(posedge aclk);
    endtask

    task automatic random_document();
        int open_elems;
        int pick;
        open_elems = 0;
        if ($urandom_range(0, 7) != 0) send(REQ_DOC_START, any_chars());
        repeat ($urandom_range(3, 30)) begin
            pick = $urandom_range(0, 99);
            if (pick < 30 && open_elems < 12) begin
                send(REQ_ELEM_START, any_chars());
                open_elems++;
            end else if (pick < 50 && open_elems > 0) begin
                send(REQ_ELEM_END, any_chars());
                open_elems--;
            end else if (pick < 70) begin
                send(REQ_TEXT, chunk_length());
            end else if (pick < 80) begin
                send(REQ_COMMENT, any_chars());
            end else if (pick < 90) begin
                send(REQ_PI, any_chars());
            end else begin
                send(3'($urandom_range(0, 7)), any_chars());
            end
        end
        // some documents are left open on purpose
        if ($urandom_range(0, 5) != 0) begin
            repeat (open_elems) send(REQ_ELEM_END, any_chars());
            send(REQ_DOC_END, any_chars());
        end
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // errors on an empty stack, empty and unknown words
        send(REQ_DOC_END, 16'd0);
        send(REQ_ELEM_END, 16'd0);
        send(REQ_COMMENT, 16'd0);
        send(REQ_PI, 16'd0);
        send(REQ_TEXT, 16'd0);
        send(REQ_RESERVED, 16'hFFFF);
        send(REQ_TEXT, 16'd1);
        send(REQ_ELEM_START, 16'd0);
        // a small document with text flushed ahead of an element start, a pi and an element end
        send(REQ_DOC_START, 16'd0);
        send(REQ_TEXT, 16'hFFFF);
        send(REQ_ELEM_START, 16'd0);
        send(REQ_COMMENT, 16'd0);
        send(REQ_TEXT, 16'h8000);
        send(REQ_PI, 16'd0);
        send(REQ_TEXT, 16'd5);
        send(REQ_ELEM_END, 16'd0);
        // nested document: doc end keeps text pending, elem end pops a document node
        send(REQ_DOC_START, 16'd0);
        send(REQ_ELEM_START, 16'd0);
        send(REQ_TEXT, 16'd3);
        send(REQ_DOC_END, 16'd0);
        send(REQ_ELEM_END, 16'd0);
        send(REQ_DOC_END, 16'd0);
        // element with no document around it
        send(REQ_ELEM_START, 16'd0);
        send(REQ_ELEM_END, 16'd0);
        send(REQ_DOC_END, 16'd0);
        drain();

        while (words_sent < 60) random_document();

        // nest down to a full stack, then unwind past the bottom
        send(REQ_DOC_START, any_chars());
        repeat (258) begin
            if ($urandom_range(0, 7) == 0) send(REQ_TEXT, chunk_length());
            send(REQ_ELEM_START, any_chars());
        end
        send(REQ_DOC_START, any_chars());
        send(REQ_COMMENT, any_chars());
        send(REQ_TEXT, 16'hFFFF);
        repeat (260) begin
            if ($urandom_range(0, 9) == 0) send(REQ_PI, any_chars());
            send(REQ_ELEM_END, any_chars());
        end
        repeat (2) send(REQ_DOC_END, any_chars());
        drain();

        while (words_sent < 650) random_document();
        drain();
        repeat (16) @(posedge aclk);

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #1_500_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- xml_pre_size_level_encoder_top.f -----
+incdir+rtl
rtl/xpse_pkg.sv
rtl/xpse_ram.sv
rtl/xml_pre_size_level_encoder_top.sv
verif/xpse_tuple_checker.sv
verif/testbench.sv
